FILE: rtl/assert_macros.svh
// Assertion macros shared by the checker modules of the maze edge joiner.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising edge, off during reset.
`define KMEJ_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kmej assertion failed");

// Next-cycle implication, sampled on the rising edge, off during reset.
`define KMEJ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kmej assertion failed");

`endif

FILE: rtl/kmej_pkg.sv
// Shared types, codes and constants of the Kruskal maze edge joiner.
// No dependencies; the RTL modules refer to it by scoped names.
`default_nettype none

package kmej_pkg;

    localparam int unsigned MAX_SIDE_DEF = 64;

    // Wall bits of a cell's mask.
    localparam logic [3:0] WALL_TOP    = 4'h1;
    localparam logic [3:0] WALL_RIGHT  = 4'h2;
    localparam logic [3:0] WALL_BOTTOM = 4'h4;
    localparam logic [3:0] WALL_LEFT   = 4'h8;
    localparam logic [3:0] WALL_ALL    = WALL_TOP | WALL_RIGHT | WALL_BOTTOM | WALL_LEFT;

    localparam logic [3:0] RANK_MAX = 4'hF;

    // Result status codes.
    localparam logic [1:0] STATUS_JOINED    = 2'd0;
    localparam logic [1:0] STATUS_CONNECTED = 2'd1;
    localparam logic [1:0] STATUS_OUT       = 2'd2;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_HEIGHT = 1'b1;

    localparam int unsigned SIDE_W = 7;
    localparam logic [SIDE_W-1:0] GRID_RESET = 7'd64;

    typedef struct packed {
        logic [5:0] cell_column;
        logic [5:0] cell_row;
        logic       edge_direction;
    } in_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] first_walls;
        logic [3:0] second_walls;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_FIND_RD,
        ST_FIND_CMP,
        ST_COMP_RD,
        ST_COMP_WR,
        ST_RANK_A,
        ST_RANK_B,
        ST_LINK,
        ST_WALL_A,
        ST_WALL_B,
        ST_WALL_FIN,
        ST_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;
        logic load;
        logic cur_a;
        logic cur_b;
        logic cur_step;
        logic side;
        logic save_root;
        logic comp_wr;
        logic rank_sel;
        logic rank_cap;
        logic link;
        logic wall_sel;
        logic wall_wr_a;
        logic wall_wr_b;
        logic res_load;
        logic res_oog;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic oog;
        logic root_hit;
        logic comp_done;
        logic same_root;
    } dp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/kmej_ctrl.sv
// Sequencing state machine of the maze edge joiner: clearing pass, bounds reject, two finds
// with path compression, rank union and wall update. Depends on kmej_pkg.
`default_nettype none

module kmej_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire kmej_pkg::dp_stat_t stat,
    output kmej_pkg::dp_cmd_t      cmd,
    output logic                   busy,
    output logic                   result_valid
);

    kmej_pkg::state_t state_reg;
    kmej_pkg::state_t state_next;
    logic             side_reg;
    logic             side_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kmej_pkg::ST_CLEAR;
            side_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            side_reg  <= side_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        side_next    = side_reg;
        cmd          = '0;
        cmd.side     = side_reg;
        busy         = 1'b1;
        result_valid = 1'b0;
        case (state_reg)
            kmej_pkg::ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = kmej_pkg::ST_IDLE;
                end
            end
            kmej_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = kmej_pkg::ST_START;
                end
            end
            kmej_pkg::ST_START:
            begin
                if (stat.oog)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_oog  = 1'b1;
                    state_next   = kmej_pkg::ST_EMIT;
                end
                else
                begin
                    cmd.cur_a  = 1'b1;
                    side_next  = 1'b0;
                    state_next = kmej_pkg::ST_FIND_RD;
                end
            end
            kmej_pkg::ST_FIND_RD:
            begin
                state_next = kmej_pkg::ST_FIND_CMP;
            end
            kmej_pkg::ST_FIND_CMP:
            begin
                if (stat.root_hit)
                begin
                    // Root found; walk the same chain again to compress it.
                    cmd.save_root = 1'b1;
                    cmd.cur_a     = !side_reg;
                    cmd.cur_b     = side_reg;
                    state_next    = kmej_pkg::ST_COMP_RD;
                end
                else
                begin
                    cmd.cur_step = 1'b1;
                    state_next   = kmej_pkg::ST_FIND_RD;
                end
            end
            kmej_pkg::ST_COMP_RD:
            begin
                if (stat.comp_done)
                begin
                    if (!side_reg)
                    begin
                        cmd.cur_b  = 1'b1;
                        side_next  = 1'b1;
                        state_next = kmej_pkg::ST_FIND_RD;
                    end
                    else if (stat.same_root)
                    begin
                        state_next = kmej_pkg::ST_WALL_A;
                    end
                    else
                    begin
                        state_next = kmej_pkg::ST_RANK_A;
                    end
                end
                else
                begin
                    state_next = kmej_pkg::ST_COMP_WR;
                end
            end
            kmej_pkg::ST_COMP_WR:
            begin
                cmd.comp_wr  = 1'b1;
                cmd.cur_step = 1'b1;
                state_next   = kmej_pkg::ST_COMP_RD;
            end
            kmej_pkg::ST_RANK_A:
            begin
                state_next = kmej_pkg::ST_RANK_B;
            end
            kmej_pkg::ST_RANK_B:
            begin
                cmd.rank_sel = 1'b1;
                cmd.rank_cap = 1'b1;
                state_next   = kmej_pkg::ST_LINK;
            end
            kmej_pkg::ST_LINK:
            begin
                cmd.link   = 1'b1;
                state_next = kmej_pkg::ST_WALL_A;
            end
            kmej_pkg::ST_WALL_A:
            begin
                state_next = kmej_pkg::ST_WALL_B;
            end
            kmej_pkg::ST_WALL_B:
            begin
                cmd.wall_sel  = 1'b1;
                cmd.wall_wr_a = 1'b1;
                state_next    = kmej_pkg::ST_WALL_FIN;
            end
            kmej_pkg::ST_WALL_FIN:
            begin
                cmd.wall_wr_b = 1'b1;
                cmd.res_load  = 1'b1;
                state_next    = kmej_pkg::ST_EMIT;
            end
            kmej_pkg::ST_EMIT:
            begin
                result_valid = 1'b1;
                state_next   = kmej_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = kmej_pkg::ST_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/kmej_dp.sv
// Datapath of the maze edge joiner: grid registers, bounds check, the parent,
// rank and wall memories, and the result register. Depends on kmej_pkg.
`default_nettype none

module kmej_dp #(
    parameter int unsigned MAX_SIDE = kmej_pkg::MAX_SIDE_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire kmej_pkg::dp_cmd_t                   cmd,
    input  wire kmej_pkg::in_item_t                  request,
    input  wire logic                                cfg_we,
    input  wire logic [kmej_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [kmej_pkg::SIDE_W-1:0]         cfg_data,
    output kmej_pkg::dp_stat_t                       stat,
    output kmej_pkg::out_item_t                      result
);

    localparam int unsigned CELLS    = MAX_SIDE * MAX_SIDE;
    localparam int unsigned AW       = $clog2(CELLS);
    localparam int unsigned SW       = kmej_pkg::SIDE_W;
    // A register value above the side limit counts as the limit.
    localparam int unsigned SIDE_CAP = (MAX_SIDE > 127) ? 127 : MAX_SIDE;

    logic [SW-1:0] width_reg;
    logic [SW-1:0] height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= kmej_pkg::GRID_RESET;
            height_reg <= kmej_pkg::GRID_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                kmej_pkg::REG_GRID_WIDTH:  width_reg  <= cfg_data;
                kmej_pkg::REG_GRID_HEIGHT: height_reg <= cfg_data;
                default:                   width_reg  <= width_reg;
            endcase
        end
    end

    // Bounds check and cell addresses of the incoming edge.
    logic [SW-1:0] grid_w;
    logic [SW-1:0] grid_h;
    logic [SW-1:0] col_w;
    logic [SW-1:0] row_w;
    logic [SW-1:0] ncol_w;
    logic [SW-1:0] nrow_w;
    logic          oog_w;
    logic [AW-1:0] addr_a_w;
    logic [AW-1:0] addr_b_w;

    always_comb
    begin
        grid_w = (width_reg > SW'(SIDE_CAP)) ? SW'(SIDE_CAP) : width_reg;
        grid_h = (height_reg > SW'(SIDE_CAP)) ? SW'(SIDE_CAP) : height_reg;
        col_w  = {1'b0, request.cell_column};
        row_w  = {1'b0, request.cell_row};
        ncol_w = request.edge_direction ? col_w : col_w + SW'(1);
        nrow_w = request.edge_direction ? row_w + SW'(1) : row_w;
        // The neighbor never lies left of or above the first cell.
        oog_w  = (ncol_w >= grid_w) || (nrow_w >= grid_h);
        addr_a_w = AW'(32'(row_w) * 32'(MAX_SIDE) + 32'(col_w));
        addr_b_w = AW'(32'(nrow_w) * 32'(MAX_SIDE) + 32'(ncol_w));
    end

    logic          oog_reg;
    logic          dir_reg;
    logic [AW-1:0] a_reg;
    logic [AW-1:0] b_reg;
    logic [AW-1:0] cur_reg;
    logic [AW-1:0] root_a_reg;
    logic [AW-1:0] root_b_reg;
    logic [AW-1:0] clr_cnt_reg;
    logic [3:0]    rka_reg;
    logic [3:0]    wa_reg;
    kmej_pkg::out_item_t res_reg;

    logic [AW-1:0] par_rd_reg;
    logic [3:0]    rank_rd_reg;
    logic [3:0]    wall_rd_reg;

    logic [AW-1:0] root_sel;
    logic          same_root;
    logic [3:0]    mask_a;
    logic [3:0]    mask_b;
    logic [3:0]    wa_new;
    logic [3:0]    wb_new;

    assign root_sel  = cmd.side ? root_b_reg : root_a_reg;
    assign same_root = (root_a_reg == root_b_reg);
    assign mask_a    = dir_reg ? kmej_pkg::WALL_BOTTOM : kmej_pkg::WALL_RIGHT;
    assign mask_b    = dir_reg ? kmej_pkg::WALL_TOP : kmej_pkg::WALL_LEFT;
    assign wa_new    = same_root ? wall_rd_reg : (wall_rd_reg & ~mask_a);
    assign wb_new    = same_root ? wall_rd_reg : (wall_rd_reg & ~mask_b);

    always_comb
    begin
        stat.clr_last  = (clr_cnt_reg == AW'(CELLS - 1));
        stat.oog       = oog_reg;
        stat.root_hit  = (par_rd_reg == cur_reg);
        stat.comp_done = (cur_reg == root_sel);
        stat.same_root = same_root;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            oog_reg <= oog_w;
            dir_reg <= request.edge_direction;
            a_reg   <= addr_a_w;
            b_reg   <= addr_b_w;
        end
        if (cmd.cur_a)
        begin
            cur_reg <= a_reg;
        end
        else if (cmd.cur_b)
        begin
            cur_reg <= b_reg;
        end
        else if (cmd.cur_step)
        begin
            cur_reg <= par_rd_reg;
        end
        if (cmd.save_root)
        begin
            if (cmd.side)
            begin
                root_b_reg <= cur_reg;
            end
            else
            begin
                root_a_reg <= cur_reg;
            end
        end
        if (cmd.rank_cap)
        begin
            rka_reg <= rank_rd_reg;
        end
        if (cmd.wall_wr_a)
        begin
            wa_reg <= wa_new;
        end
        if (cmd.res_load)
        begin
            if (cmd.res_oog)
            begin
                res_reg <= '{status: kmej_pkg::STATUS_OUT, first_walls: 4'h0,
                             second_walls: 4'h0};
            end
            else
            begin
                res_reg.status       <= same_root ? kmej_pkg::STATUS_CONNECTED
                                                  : kmej_pkg::STATUS_JOINED;
                res_reg.first_walls  <= wa_reg;
                res_reg.second_walls <= wb_new;
            end
        end
    end

    assign result = res_reg;

    // Write ports of the three memories.
    logic          par_we;
    logic [AW-1:0] par_wa;
    logic [AW-1:0] par_wd;
    logic          rank_we;
    logic [AW-1:0] rank_wa;
    logic [3:0]    rank_wd;
    logic          wall_we;
    logic [AW-1:0] wall_wa;
    logic [3:0]    wall_wd;
    logic [3:0]    rkb;

    assign rkb = rank_rd_reg;

    always_comb
    begin
        par_we  = 1'b0;
        par_wa  = cur_reg;
        par_wd  = root_sel;
        rank_we = 1'b0;
        rank_wa = root_a_reg;
        rank_wd = rka_reg + 4'd1;
        wall_we = 1'b0;
        wall_wa = a_reg;
        wall_wd = wa_new;
        if (cmd.clear)
        begin
            par_we  = 1'b1;
            par_wa  = clr_cnt_reg;
            par_wd  = clr_cnt_reg;
            rank_we = 1'b1;
            rank_wa = clr_cnt_reg;
            rank_wd = 4'd0;
            wall_we = 1'b1;
            wall_wa = clr_cnt_reg;
            wall_wd = kmej_pkg::WALL_ALL;
        end
        else
        begin
            if (cmd.comp_wr)
            begin
                par_we = 1'b1;
            end
            else if (cmd.link)
            begin
                // Union by rank: the lower tree hangs below the higher one.
                par_we = 1'b1;
                if (rka_reg < rkb)
                begin
                    par_wa = root_a_reg;
                    par_wd = root_b_reg;
                end
                else
                begin
                    par_wa = root_b_reg;
                    par_wd = root_a_reg;
                    rank_we = (rka_reg == rkb) && (rka_reg != kmej_pkg::RANK_MAX);
                end
            end
            if (cmd.wall_wr_a)
            begin
                wall_we = 1'b1;
            end
            else if (cmd.wall_wr_b)
            begin
                wall_we = 1'b1;
                wall_wa = b_reg;
                wall_wd = wb_new;
            end
        end
    end

    logic [AW-1:0] par_mem  [CELLS];
    logic [3:0]    rank_mem [CELLS];
    logic [3:0]    wall_mem [CELLS];

    always_ff @(posedge clk)
    begin
        if (par_we)
        begin
            par_mem[par_wa] <= par_wd;
        end
        par_rd_reg <= par_mem[cur_reg];
    end

    always_ff @(posedge clk)
    begin
        if (rank_we)
        begin
            rank_mem[rank_wa] <= rank_wd;
        end
        rank_rd_reg <= rank_mem[cmd.rank_sel ? root_b_reg : root_a_reg];
    end

    always_ff @(posedge clk)
    begin
        if (wall_we)
        begin
            wall_mem[wall_wa] <= wall_wd;
        end
        wall_rd_reg <= wall_mem[cmd.wall_sel ? b_reg : a_reg];
    end

endmodule

`default_nettype wire

FILE: rtl/kruskal_maze_edge_joiner.sv
// An out-of-grid edge goes from the bounds check straight to its result; an edge in the grid
// takes longer the more parent links lie above its two cells, as the parent memory has a single
// read port, and is shorter when already connected, since the rank union is skipped.
// One edge is in work at a time; the next is accepted in the cycle after the result strobe.
// After reset a clearing pass over all MAX_SIDE*MAX_SIDE cells (4096 by default) keeps busy high.
// Results are shown for one cycle with result_valid; the receiver cannot stall.
`default_nettype none

module kruskal_maze_edge_joiner #(
    parameter int unsigned MAX_SIDE = kmej_pkg::MAX_SIDE_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire kmej_pkg::in_item_t               request,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [kmej_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [kmej_pkg::SIDE_W-1:0]      cfg_data,
    output kmej_pkg::out_item_t                   result,
    output logic                                  result_valid
);

    kmej_pkg::dp_cmd_t  cmd;
    kmej_pkg::dp_stat_t stat;

    // Grid registers are always writable; the user must write them only while idle, the block does not enforce it.
    assign cfg_ready = 1'b1;

    kmej_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .stat         (stat),
        .cmd          (cmd),
        .busy         (busy),
        .result_valid (result_valid)
    );

    kmej_dp #(
        .MAX_SIDE (MAX_SIDE)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .request   (request),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .stat      (stat),
        .result    (result)
    );

endmodule

`default_nettype wire

FILE: rtl/kmej_checker.sv
// Port-level checks of the maze edge joiner, bound to the top level.
// Depends on kmej_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module kmej_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                start,
    input wire logic                busy,
    input wire logic                result_valid,
    input wire kmej_pkg::out_item_t result
);

    logic oog_result;
    logic no_walls;

    assign oog_result = result_valid && (result.status == kmej_pkg::STATUS_OUT);
    assign no_walls   = (result.first_walls == 4'h0) && (result.second_walls == 4'h0);

    // An accepted transaction holds the block busy and gives no result at once.
    `KMEJ_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !result_valid)

    // A result strobe lasts exactly one cycle.
    `KMEJ_ASSERT_NEXT(a_strobe_single, result_valid, !result_valid)

    // A result only appears while a transaction is in work.
    `KMEJ_ASSERT_SAME(a_result_busy, result_valid, busy)

    // An out-of-grid result reports no walls.
    `KMEJ_ASSERT_SAME(a_oog_walls, oog_result, no_walls)

endmodule

bind kruskal_maze_edge_joiner kmej_checker u_kmej_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);

`default_nettype wire
